@@ design/rrru_pkg.sv @@
// Shared types and constants for the register rename and retire unit.
`default_nettype none
package rrru_pkg;
   typedef enum logic [1:0] {
      ACT_RENAME    = 2'd0,
      ACT_WRITEBACK = 2'd1,
      ACT_COMMIT    = 2'd2,
      ACT_RECOVER   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_STALL   = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_WALK,
      S_WALK_WAIT,
      S_OUT
   } state_type;
endpackage
`default_nettype wire

@@ design/register_rename_retire_unit_core.sv @@
// Top level of the register rename and retire unit.
// Sequence from accept to response valid: rename passes READ, EXEC, OUT; writeback adds
// WALK_WAIT for an in-range entry; commit and recovery add WALK, WALK_WAIT per entry examined
// (at most RETIRE_WIDTH). Flow: one request in flight; the next is taken the cycle after
// the response leaves. The active-list read port sets the walk rate.
// Reset: synchronous, sets map to identity, refills free list, clears busy and register-file valid bits and pointers.
`default_nettype none
module register_rename_retire_unit_core #(
   parameter int ACTIVE_DEPTH = 32,
   parameter int PHYS_REGS    = 64,
   parameter int LOG_REGS     = 32,
   parameter int RETIRE_WIDTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [4:0]  req_logical_dest,
   input  wire logic [4:0]  req_logical_src_a,
   input  wire logic [4:0]  req_logical_src_b,
   input  wire logic        req_use_immediate,
   input  wire logic signed [63:0] req_immediate_value,
   input  wire logic [31:0] req_instr_pc,
   input  wire logic [5:0]  req_wb_phys_reg,
   input  wire logic [63:0] req_wb_value,
   input  wire logic [4:0]  req_wb_entry,
   input  wire logic        req_wb_exception,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_entry_index,
   output logic [5:0]       rsp_phys_dest,
   output logic             rsp_a_ready,
   output logic [5:0]       rsp_a_tag,
   output logic [63:0]      rsp_a_value,
   output logic             rsp_b_ready,
   output logic [5:0]       rsp_b_tag,
   output logic [63:0]      rsp_b_value,
   output logic             rsp_exception_mode,
   output logic [31:0]      rsp_exception_pc,
   output logic [2:0]       rsp_handled_count
);
   localparam int AW = $clog2(ACTIVE_DEPTH);
   localparam int PW = $clog2(PHYS_REGS);
   localparam int LW = $clog2(LOG_REGS);
   localparam int FREE_DEPTH = PHYS_REGS - LOG_REGS;
   localparam int FW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
   localparam int RW = $clog2(RETIRE_WIDTH + 1);

   // Active-list entry: done, exception, logical dest, old dest, pc, dest.
   typedef struct packed {
      logic          done;
      logic          exc;
      logic [LW-1:0] lreg;
      logic [PW-1:0] prev_dest;
      logic [31:0]   pc;
      logic [PW-1:0] dest;
   } al_entry_type;

   // Small state in flip-flops: map, free ring, busy bits.
   logic [PW-1:0] map_ff [LOG_REGS];
   logic [PW-1:0] free_ff [FREE_DEPTH];
   logic [FW-1:0] free_head_ff;
   logic [FW:0]   free_count_ff;
   logic [PHYS_REGS-1:0] busy_ff;
   logic [PHYS_REGS-1:0] pvalid_ff;   // register file entry written since reset
   logic [AW-1:0] head_ff, tail_ff;
   logic [AW:0]   count_ff;
   logic          exc_ff;
   logic [31:0]   saved_pc_ff;

   // Memories: register file (two read ports) and active list.
   logic [63:0]        prf_mem [PHYS_REGS];
   al_entry_type       al_mem  [ACTIVE_DEPTH];
   logic [63:0]        prf_a_q, prf_b_q;
   al_entry_type       al_q;
   logic               prf_we;
   logic [PW-1:0]      prf_wa, prf_ra, prf_rb;
   logic [63:0]        prf_wd;
   logic               al_we;
   logic [AW-1:0]      al_wa, al_ra;
   al_entry_type       al_wd;

   always_ff @(posedge clock) begin
      if (prf_we) prf_mem[prf_wa] <= prf_wd;
      prf_a_q <= prf_mem[prf_ra];
      prf_b_q <= prf_mem[prf_rb];
   end

   always_ff @(posedge clock) begin
      if (al_we) al_mem[al_wa] <= al_wd;
      al_q <= al_mem[al_ra];
   end

   rrru_pkg::state_type state_ff, state_in;

   // Captured request.
   logic [1:0]  act_ff;
   logic [LW-1:0] ld_ff;
   logic [PW-1:0] pa_ff, pb_ff;
   logic        imm_ff;
   logic [63:0] imm_ff_v;
   logic [31:0] pc_ff;
   logic [5:0]  wpr_ff;
   logic [63:0] wval_ff;
   logic [4:0]  wen_ff;
   logic        wexc_ff;
   logic [RW-1:0] n_ff;

   // Response register.
   logic [1:0]  o_status_ff;
   logic [4:0]  o_entry_ff;
   logic [5:0]  o_pdest_ff;
   logic        o_ar_ff, o_br_ff;
   logic [5:0]  o_at_ff, o_bt_ff;
   logic [63:0] o_av_ff, o_bv_ff;

   assign req_ready = (state_ff == rrru_pkg::S_IDLE);
   assign rsp_valid = (state_ff == rrru_pkg::S_OUT);
   assign rsp_status = o_status_ff;
   assign rsp_entry_index = o_entry_ff;
   assign rsp_phys_dest = o_pdest_ff;
   assign rsp_a_ready = o_ar_ff;
   assign rsp_a_tag = o_at_ff;
   assign rsp_a_value = o_av_ff;
   assign rsp_b_ready = o_br_ff;
   assign rsp_b_tag = o_bt_ff;
   assign rsp_b_value = o_bv_ff;
   assign rsp_exception_mode = exc_ff;
   assign rsp_exception_pc = saved_pc_ff;
   assign rsp_handled_count = 3'(n_ff);

   // Walk pointer: head for commit, entry below tail for recovery.
   logic [AW-1:0] tail_dec;
   assign tail_dec = (tail_ff == '0) ? AW'(ACTIVE_DEPTH - 1) : tail_ff - 1'b1;
   logic [AW-1:0] head_inc, tail_inc;
   assign head_inc = (head_ff == AW'(ACTIVE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_inc = (tail_ff == AW'(ACTIVE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;

   logic [LW-1:0] la_sel, lb_sel;
   assign la_sel = LW'(32'(req_logical_src_a) % LOG_REGS);
   assign lb_sel = LW'(32'(req_logical_src_b) % LOG_REGS);

   logic walk_more;
   assign walk_more = (32'(n_ff) < RETIRE_WIDTH) && (count_ff != '0);

   logic [FW-1:0] free_head_inc, free_tailp;
   assign free_head_inc = (32'(free_head_ff) == FREE_DEPTH - 1) ? '0 : free_head_ff + 1'b1;
   assign free_tailp = FW'((32'(free_head_ff) + 32'(free_count_ff)) % FREE_DEPTH);
   logic free_full;
   assign free_full = (32'(free_count_ff) >= FREE_DEPTH);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrru_pkg::S_IDLE: if (req_valid) state_in = rrru_pkg::S_READ;
         rrru_pkg::S_READ: state_in = rrru_pkg::S_EXEC;
         rrru_pkg::S_EXEC: begin
            if (!exc_ff && act_ff == rrru_pkg::ACT_COMMIT && walk_more)
               state_in = rrru_pkg::S_WALK;
            else if (exc_ff && act_ff == rrru_pkg::ACT_RECOVER && walk_more)
               state_in = rrru_pkg::S_WALK;
            else
               state_in = rrru_pkg::S_OUT;
         end
         rrru_pkg::S_WALK: state_in = rrru_pkg::S_WALK_WAIT;
         rrru_pkg::S_WALK_WAIT: begin
            if (act_ff == rrru_pkg::ACT_COMMIT) begin
               if (!al_q.done || al_q.exc || !(32'(n_ff) + 1 < RETIRE_WIDTH)
                   || count_ff == (AW+1)'(1))
                  state_in = rrru_pkg::S_OUT;
               else
                  state_in = rrru_pkg::S_WALK;
            end else begin
               if (!(32'(n_ff) + 1 < RETIRE_WIDTH) || count_ff == (AW+1)'(1))
                  state_in = rrru_pkg::S_OUT;
               else
                  state_in = rrru_pkg::S_WALK;
            end
         end
         rrru_pkg::S_OUT: if (rsp_ready) state_in = rrru_pkg::S_IDLE;
         default: state_in = rrru_pkg::S_IDLE;
      endcase
   end

   // Memory port controls.
   always_comb begin
      prf_we = 1'b0;
      prf_wa = wpr_ff[PW-1:0];
      prf_wd = wval_ff;
      // Read the captured source tags; the request ports may already carry the next request.
      prf_ra = pa_ff;
      prf_rb = pb_ff;
      al_we = 1'b0;
      al_wa = tail_ff;
      al_wd = '0;
      al_ra = (act_ff == rrru_pkg::ACT_COMMIT) ? head_ff : tail_dec;
      if (state_ff == rrru_pkg::S_EXEC) begin
         if (act_ff == rrru_pkg::ACT_RENAME && !exc_ff && !(32'(count_ff) >= ACTIVE_DEPTH)
             && free_count_ff != '0) begin
            al_we = 1'b1;
            al_wa = tail_ff;
            al_wd.done = 1'b0;
            al_wd.exc = 1'b0;
            al_wd.lreg = ld_ff;
            al_wd.prev_dest = map_ff[ld_ff];
            al_wd.pc = pc_ff;
            al_wd.dest = free_ff[free_head_ff];
         end
         if (act_ff == rrru_pkg::ACT_WRITEBACK && !exc_ff) begin
            prf_we = !wexc_ff && (32'(wpr_ff) < PHYS_REGS);
         end
      end
      // Writeback marks the entry: read-modify-write through al_q.
      if (state_ff == rrru_pkg::S_WALK_WAIT && act_ff == rrru_pkg::ACT_WRITEBACK) begin
         al_we = 1'b1;
         al_wa = wen_ff[AW-1:0];
         al_wd = al_q;
         al_wd.done = 1'b1;
         if (wexc_ff) al_wd.exc = 1'b1;
      end
      if (state_ff == rrru_pkg::S_EXEC && act_ff == rrru_pkg::ACT_WRITEBACK)
         al_ra = wen_ff[AW-1:0];
   end

   // Writeback entry update goes EXEC -> WALK_WAIT when in range and not in exception mode.
   logic wb_entry_ok;
   assign wb_entry_ok = (32'(wen_ff) < ACTIVE_DEPTH);

   rrru_pkg::state_type state_fix;
   always_comb begin
      state_fix = state_in;
      if (state_ff == rrru_pkg::S_EXEC && act_ff == rrru_pkg::ACT_WRITEBACK && !exc_ff
          && wb_entry_ok)
         state_fix = rrru_pkg::S_WALK_WAIT;
      if (state_ff == rrru_pkg::S_WALK_WAIT && act_ff == rrru_pkg::ACT_WRITEBACK)
         state_fix = rrru_pkg::S_OUT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrru_pkg::S_IDLE;
         for (int i = 0; i < LOG_REGS; i++) map_ff[i] <= PW'(i);
         for (int i = 0; i < FREE_DEPTH; i++) free_ff[i] <= PW'(LOG_REGS + i);
         free_head_ff <= '0;
         free_count_ff <= (FW+1)'(FREE_DEPTH);
         busy_ff <= '0;
         pvalid_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         exc_ff <= 1'b0;
         saved_pc_ff <= '0;
         n_ff <= '0;
      end else begin
         state_ff <= state_fix;
         case (state_ff)
            rrru_pkg::S_IDLE: begin
               if (req_valid) begin
                  // Capture the request; map lookups happen now, before any rename.
                  act_ff <= req_action;
                  ld_ff <= LW'(32'(req_logical_dest) % LOG_REGS);
                  pa_ff <= map_ff[la_sel];
                  pb_ff <= map_ff[lb_sel];
                  imm_ff <= req_use_immediate;
                  imm_ff_v <= req_immediate_value;
                  pc_ff <= req_instr_pc;
                  wpr_ff <= req_wb_phys_reg;
                  wval_ff <= req_wb_value;
                  wen_ff <= req_wb_entry;
                  wexc_ff <= req_wb_exception;
                  n_ff <= '0;
               end
            end
            rrru_pkg::S_EXEC: begin
               o_status_ff <= rrru_pkg::ST_DONE;
               o_entry_ff <= '0;
               o_pdest_ff <= '0;
               o_ar_ff <= 1'b0; o_at_ff <= '0; o_av_ff <= '0;
               o_br_ff <= 1'b0; o_bt_ff <= '0; o_bv_ff <= '0;
               if (exc_ff && act_ff != rrru_pkg::ACT_RECOVER) begin
                  o_status_ff <= rrru_pkg::ST_REFUSED;
               end else if (act_ff == rrru_pkg::ACT_RENAME) begin
                  if (32'(count_ff) >= ACTIVE_DEPTH || free_count_ff == '0) begin
                     o_status_ff <= rrru_pkg::ST_STALL;
                  end else begin
                     if (!busy_ff[pa_ff]) begin
                        o_ar_ff <= 1'b1;
                        o_av_ff <= pvalid_ff[pa_ff] ? prf_a_q : '0;
                     end else o_at_ff <= 6'(pa_ff);
                     if (imm_ff) begin
                        o_br_ff <= 1'b1;
                        o_bv_ff <= imm_ff_v;
                     end else if (!busy_ff[pb_ff]) begin
                        o_br_ff <= 1'b1;
                        o_bv_ff <= pvalid_ff[pb_ff] ? prf_b_q : '0;
                     end else o_bt_ff <= 6'(pb_ff);
                     busy_ff[free_ff[free_head_ff]] <= 1'b1;
                     map_ff[ld_ff] <= free_ff[free_head_ff];
                     o_entry_ff <= 5'(tail_ff);
                     o_pdest_ff <= 6'(free_ff[free_head_ff]);
                     free_head_ff <= free_head_inc;
                     free_count_ff <= free_count_ff - 1'b1;
                     tail_ff <= tail_inc;
                     count_ff <= count_ff + 1'b1;
                  end
               end else if (act_ff == rrru_pkg::ACT_WRITEBACK) begin
                  if (!wexc_ff && 32'(wpr_ff) < PHYS_REGS) begin
                     busy_ff[wpr_ff[PW-1:0]] <= 1'b0;
                     pvalid_ff[wpr_ff[PW-1:0]] <= 1'b1;
                  end
               end else if (act_ff == rrru_pkg::ACT_RECOVER && !exc_ff) begin
                  o_status_ff <= rrru_pkg::ST_DONE;
               end else if (act_ff == rrru_pkg::ACT_RECOVER && count_ff == '0) begin
                  exc_ff <= 1'b0;
               end
            end
            rrru_pkg::S_WALK_WAIT: begin
               if (act_ff == rrru_pkg::ACT_COMMIT) begin
                  if (al_q.done && al_q.exc) begin
                     exc_ff <= 1'b1;
                     saved_pc_ff <= al_q.pc;
                  end else if (al_q.done) begin
                     if (!free_full) begin
                        free_ff[free_tailp] <= al_q.prev_dest;
                        free_count_ff <= free_count_ff + 1'b1;
                     end
                     head_ff <= head_inc;
                     count_ff <= count_ff - 1'b1;
                     n_ff <= n_ff + 1'b1;
                  end
               end else if (act_ff == rrru_pkg::ACT_RECOVER) begin
                  if (!free_full) begin
                     free_ff[free_tailp] <= al_q.dest;
                     free_count_ff <= free_count_ff + 1'b1;
                  end
                  busy_ff[al_q.dest] <= 1'b0;
                  map_ff[al_q.lreg] <= al_q.prev_dest;
                  tail_ff <= tail_dec;
                  count_ff <= count_ff - 1'b1;
                  n_ff <= n_ff + 1'b1;
                  if (count_ff == (AW+1)'(1)) exc_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ design/rrru_checker.sv @@
// Port-level checker for the rename and retire unit, bound to the top level.
`default_nettype none
module rrru_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_exception_mode,
   input wire logic [2:0] rsp_handled_count
);
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request accepted while response pending");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("response too early");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 2'(rrru_pkg::ST_REFUSED)) else $error("bad status");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_handled_count <= 3'd4) else $error("handled count too large");
   a_refused_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == 2'(rrru_pkg::ST_REFUSED)) |-> rsp_exception_mode)
      else $error("refusal outside exception mode");
endmodule

bind register_rename_retire_unit_core rrru_checker u_rrru_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_exception_mode(rsp_exception_mode), .rsp_handled_count(rsp_handled_count)
);
`default_nettype wire
